/* rtl/uart_dual_ring_buffer_macros.svh */
// Assertion macros used by the block's checker.
`ifndef UART_DUAL_RING_BUFFER_MACROS_SVH
`define UART_DUAL_RING_BUFFER_MACROS_SVH

// Checked only out of reset.
`define UDRB_ASSERT_RUN(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define UDRB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/udrb_pkg.sv */
// Types, opcodes and defaults of the UART dual ring buffer.
`default_nettype none

package udrb_pkg;

	localparam int DEFAULT_BUFFER_DEPTH = 8;

	typedef enum logic [2:0] {
		OP_TX_WRITE = 3'd0,
		OP_TX_READY = 3'd1,
		OP_RX_BYTE  = 3'd2,
		OP_RX_READ  = 3'd3,
		OP_FLUSH_RX = 3'd4,
		OP_FLUSH_TX = 3'd5
	} opcode_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       write_refused;
		logic       rx_overrun;
		logic       tx_pending;
		logic [3:0] tx_fill;
		logic [3:0] rx_fill;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} ctrl_state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic capture;
		logic exec;
		logic load;
	} dp_cmd_t;

endpackage

`default_nettype wire

/* rtl/udrb_ctrl.sv */
// Controller state machine: beat sequencing and response valid.
`default_nettype none

module udrb_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output udrb_pkg::dp_cmd_t      cmd
);

	udrb_pkg::ctrl_state_t state_q, state_d;
	logic rsp_valid_q;
	logic slot_free;

	assign slot_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			udrb_pkg::ST_IDLE: begin
				if (in_valid) state_d = udrb_pkg::ST_EXEC;
			end
			udrb_pkg::ST_EXEC: begin
				state_d = udrb_pkg::ST_LOAD;
			end
			udrb_pkg::ST_LOAD: begin
				if (slot_free) state_d = udrb_pkg::ST_IDLE;
			end
			default: begin
				state_d = udrb_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			udrb_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			udrb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			udrb_pkg::ST_LOAD: begin
				cmd.load = slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= udrb_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

/* rtl/udrb_datapath.sv */
// Datapath: both byte stores, pointers, counts and the response register.
`default_nettype none

module udrb_datapath #(
	parameter int BUFFER_DEPTH = udrb_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire udrb_pkg::dp_cmd_t   cmd,
	input  wire udrb_pkg::in_item_t  in_item,
	output udrb_pkg::rsp_item_t      rsp_item
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(BUFFER_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(BUFFER_DEPTH);

	logic [7:0] tx_mem [BUFFER_DEPTH];
	logic [7:0] rx_mem [BUFFER_DEPTH];

	logic [2:0]       op_q;
	logic [7:0]       data_q;
	logic [PTR_W-1:0] tx_rd_q, tx_wr_q, rx_rd_q, rx_wr_q;
	logic [CNT_W-1:0] tx_cnt_q, rx_cnt_q;
	logic [7:0]       tx_rdata_q, rx_rdata_q;
	logic             pend_valid_q, pend_refused_q, pend_overrun_q, pend_rx_q;

	logic [PTR_W-1:0] tx_rd_d, tx_wr_d, rx_rd_d, rx_wr_d;
	logic [CNT_W-1:0] tx_cnt_d, rx_cnt_d;
	logic             tx_we, rx_we, pop_valid, refused, overrun, pop_rx;
	logic [CNT_W+3:0] tx_cnt_ext, rx_cnt_ext;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
	endfunction

	// Step decode on the captured opcode
	always_comb begin
		tx_rd_d   = tx_rd_q;
		tx_wr_d   = tx_wr_q;
		rx_rd_d   = rx_rd_q;
		rx_wr_d   = rx_wr_q;
		tx_cnt_d  = tx_cnt_q;
		rx_cnt_d  = rx_cnt_q;
		tx_we     = 1'b0;
		rx_we     = 1'b0;
		pop_valid = 1'b0;
		refused   = 1'b0;
		overrun   = 1'b0;
		pop_rx    = 1'b0;
		unique case (op_q)
			udrb_pkg::OP_TX_WRITE: begin
				if (tx_cnt_q == FULL_CNT) begin
					refused = 1'b1;
				end else begin
					tx_we    = 1'b1;
					tx_wr_d  = advance(tx_wr_q);
					tx_cnt_d = tx_cnt_q + CNT_W'(1);
				end
			end
			udrb_pkg::OP_TX_READY: begin
				if (tx_cnt_q != '0) begin
					pop_valid = 1'b1;
					tx_rd_d   = advance(tx_rd_q);
					tx_cnt_d  = tx_cnt_q - CNT_W'(1);
				end
			end
			udrb_pkg::OP_RX_BYTE: begin
				rx_we   = 1'b1;
				rx_wr_d = advance(rx_wr_q);
				if (rx_cnt_q != FULL_CNT) begin
					rx_cnt_d = rx_cnt_q + CNT_W'(1);
				end else begin
					rx_rd_d = advance(rx_rd_q);
					overrun = 1'b1;
				end
			end
			udrb_pkg::OP_RX_READ: begin
				pop_rx = 1'b1;
				if (rx_cnt_q != '0) begin
					pop_valid = 1'b1;
					rx_rd_d   = advance(rx_rd_q);
					rx_cnt_d  = rx_cnt_q - CNT_W'(1);
				end
			end
			udrb_pkg::OP_FLUSH_RX: begin
				rx_rd_d  = '0;
				rx_wr_d  = '0;
				rx_cnt_d = '0;
			end
			udrb_pkg::OP_FLUSH_TX: begin
				tx_rd_d  = '0;
				tx_wr_d  = '0;
				tx_cnt_d = '0;
			end
			default: begin
				pop_valid = 1'b0;
			end
		endcase
	end

	// Stores: one write and one registered read each
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (tx_we) tx_mem[tx_wr_q] <= data_q;
			tx_rdata_q <= tx_mem[tx_rd_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (rx_we) rx_mem[rx_wr_q] <= data_q;
			rx_rdata_q <= rx_mem[rx_rd_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_rd_q  <= '0;
			tx_wr_q  <= '0;
			rx_rd_q  <= '0;
			rx_wr_q  <= '0;
			tx_cnt_q <= '0;
			rx_cnt_q <= '0;
		end else if (cmd.exec) begin
			tx_rd_q  <= tx_rd_d;
			tx_wr_q  <= tx_wr_d;
			rx_rd_q  <= rx_rd_d;
			rx_wr_q  <= rx_wr_d;
			tx_cnt_q <= tx_cnt_d;
			rx_cnt_q <= rx_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_item.opcode;
			data_q <= in_item.data_byte;
		end
		if (cmd.exec) begin
			pend_valid_q   <= pop_valid;
			pend_refused_q <= refused;
			pend_overrun_q <= overrun;
			pend_rx_q      <= pop_rx;
		end
	end

	// Fill fields report the low four bits of the counts
	assign tx_cnt_ext = {4'b0000, tx_cnt_q};
	assign rx_cnt_ext = {4'b0000, rx_cnt_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_item.out_byte      <= pend_valid_q ? (pend_rx_q ? rx_rdata_q : tx_rdata_q)
			                                       : 8'h00;
			rsp_item.out_valid     <= pend_valid_q;
			rsp_item.write_refused <= pend_refused_q;
			rsp_item.rx_overrun    <= pend_overrun_q;
			rsp_item.tx_pending    <= (tx_cnt_q != '0);
			rsp_item.tx_fill       <= tx_cnt_ext[3:0];
			rsp_item.rx_fill       <= rx_cnt_ext[3:0];
		end
	end

endmodule

`default_nettype wire

/* rtl/uart_dual_ring_buffer.sv */
// Top level of the UART dual ring buffer: transmit and receive byte queues.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------
//   in      | input     | in_valid / in_ready    | in_item  (opcode, byte)
//   rsp     | output    | rsp_valid / rsp_ready  | rsp_item (byte, flags, fills)
//
// Each beat passes capture, execute (queue update and store read) and load
// into the response register, in that order.
// One beat is in flight at a time; the next is taken while a finished
// response still waits in the response register.
// arst_n empties both queues at once; store contents stay undefined until
// written and are never returned unread.
// A stalled response holds the load step, and with it the next beat.
`default_nettype none

module uart_dual_ring_buffer #(
	parameter int BUFFER_DEPTH = udrb_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire udrb_pkg::in_item_t  in_item,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output udrb_pkg::rsp_item_t      rsp_item
);

	// Commands from the sequencer into the queue datapath
	udrb_pkg::dp_cmd_t cmd;

	udrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// Both queues, their pointers and counts, and the response register
	udrb_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.rsp_item (rsp_item)
	);

endmodule

`default_nettype wire

/* rtl/udrb_checker.sv */
// Port-level checker for the UART dual ring buffer, with its bind.
`default_nettype none

`include "uart_dual_ring_buffer_macros.svh"

module udrb_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire udrb_pkg::rsp_item_t rsp_item
);

	`UDRB_ASSERT_RUN(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item), "response dropped or changed while stalled")

	`UDRB_ASSERT_RUN(a_one_in_flight, in_valid && in_ready |=> !in_ready, "second beat taken while one is in flight")

	`UDRB_ASSERT_RUN(a_pending_fill, rsp_valid |-> (rsp_item.tx_pending == (rsp_item.tx_fill != 4'd0) || rsp_item.tx_pending), "tx pending disagrees with empty fill")

	`UDRB_ASSERT_RUN(a_idle_byte, rsp_valid && !rsp_item.out_valid |-> rsp_item.out_byte == 8'h00, "byte present without pop")

	// An edge seen in reset clears the response flag for the next edge.
	`UDRB_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !rsp_valid, "response valid after reset")

endmodule

bind uart_dual_ring_buffer udrb_checker u_checker (.*);

`default_nettype wire
